// ===== hdl/tbds_pkg.sv =====
// Shared types and constants of the 2x2 box downsampler.
package tbds_pkg;

  localparam int unsigned LANES    = 5;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned LANE_W   = SAMPLE_W + 1;
  localparam int unsigned SUM_W    = SAMPLE_W + 2;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned QUAD_W   = 2;
  localparam int unsigned CFG_W    = 3;

  localparam logic [CFG_W-1:0] CHANNEL_COUNT_RST = CFG_W'(4);

  typedef enum logic [QUAD_W-1:0] {
    QUAD_TOP_LEFT     = 2'd0,
    QUAD_TOP_RIGHT    = 2'd1,
    QUAD_BOTTOM_RIGHT = 2'd2,
    QUAD_BOTTOM_LEFT  = 2'd3
  } quad_e;

  typedef logic [LANES-1:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    logic [QUAD_W-1:0]   quadrant;
    logic                first_of_tile;
    logic [SAMPLE_W-1:0] chan_0;
    logic [SAMPLE_W-1:0] chan_1;
    logic [SAMPLE_W-1:0] chan_2;
    logic [SAMPLE_W-1:0] chan_3;
    logic [SAMPLE_W-1:0] chan_4;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  dst_x;
    logic [COORD_W-1:0]  dst_y;
    logic [SAMPLE_W-1:0] avg_0;
    logic [SAMPLE_W-1:0] avg_1;
    logic [SAMPLE_W-1:0] avg_2;
    logic [SAMPLE_W-1:0] avg_3;
    logic [SAMPLE_W-1:0] avg_4;
  } out_item_t;

  // Read request issued by the front end toward the averaging stage.
  typedef struct packed {
    logic               rd;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    lanes_t             pairs;
  } issue_t;

endpackage

// ===== hdl/tbds_stream_if.sv =====
// Valid/ready stream interface carrying one request payload.
interface tbds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tile_box_downsample_2x.sv =====
// Top level of the 2x2 box downsampler that merges four tiles into one.
//
// The block takes one source pixel per cycle, in row-major order, from four
// source tiles (top-left, top-right, bottom-right, bottom-left) and writes a
// half-resolution destination pixel for every even-aligned 2x2 block: per
// channel, the sum of the four samples shifted right by two. A request on
// in_i whose first_of_tile bit is set restarts the column and row counters.
// The result of a block is formed from its bottom-right pixel, passes stage
// one and the output register, and carries its destination coordinates with
// the quadrant offset of TILE_WIDTH/2 applied. Horizontal pair sums of even
// rows sit in a line buffer RAM of TILE_WIDTH/2 entries that the odd row
// reads back through its single read port; the sustained rate is one pixel
// per cycle as long as out_o is drained. Channels numbered at or above
// channel_count, or at or above MAX_CHANNELS, read zero; channel_count
// (reset value 4) is applied when a result is formed and should be written
// only while the block is idle. The line buffer has no reset and needs no
// clearing, because every entry is written by an even row before the odd
// row below reads it.
module tile_box_downsample_2x #(
  parameter int unsigned TILE_WIDTH   = 64,
  parameter int unsigned MAX_CHANNELS = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tbds_pkg::CFG_W-1:0]   cfg_data_i,
  tbds_stream_if.sink                  in_i,
  tbds_stream_if.source                out_o
);

  localparam int unsigned HALF = TILE_WIDTH / 2;
  localparam int unsigned AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned MW   = MAX_CHANNELS * tbds_pkg::LANE_W;
  localparam int unsigned FW   = tbds_pkg::LANES * tbds_pkg::LANE_W;

  logic [tbds_pkg::CFG_W-1:0] cfg_q;

  logic                       accept;
  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [MW-1:0]              ram_wdata, ram_rdata;
  tbds_pkg::issue_t           issue;

  // Stage one waits for the line buffer read; the output register follows.
  logic                       s1_valid_q;
  tbds_pkg::issue_t           s1_q;
  logic                       out_valid_q;
  tbds_pkg::out_item_t        out_q, out_d;
  logic                       advance;

  tbds_pkg::lanes_t                                 top_lanes;
  logic [tbds_pkg::LANES-1:0][tbds_pkg::SAMPLE_W-1:0] avg;
  logic [tbds_pkg::SUM_W-1:0]                       sum;

  // The pipeline moves whenever the output register is empty or drained.
  // While stage one holds a result that cannot move, no new read may
  // overwrite the RAM read register, so input requests are held off.
  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = advance || !s1_valid_q;
  assign accept    = in_i.valid && in_i.ready;

  tbds_front #(
    .TILE_WIDTH   (TILE_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.data),
    .we_o     (ram_we),
    .addr_o   (ram_addr),
    .wdata_o  (ram_wdata),
    .issue_o  (issue)
  );

  tbds_ram #(
    .WIDTH (MW),
    .DEPTH (HALF),
    .AW    (AW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (issue.rd),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    top_lanes = tbds_pkg::lanes_t'(FW'(ram_rdata));
    sum       = '0;
    for (int c = 0; c < int'(tbds_pkg::LANES); c++) begin
      sum = {1'b0, top_lanes[c]} + {1'b0, s1_q.pairs[c]};
      if (c < int'(MAX_CHANNELS) && c < int'(cfg_q)) begin
        avg[c] = sum[tbds_pkg::SUM_W-1:2];
      end else begin
        avg[c] = '0;
      end
    end
    out_d.dst_x = s1_q.dst_x;
    out_d.dst_y = s1_q.dst_y;
    out_d.avg_0 = avg[0];
    out_d.avg_1 = avg[1];
    out_d.avg_2 = avg[2];
    out_d.avg_3 = avg[3];
    out_d.avg_4 = avg[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= tbds_pkg::CHANNEL_COUNT_RST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance || !s1_valid_q) begin
        s1_valid_q <= issue.rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_q <= out_d;
    end
    if (issue.rd) begin
      s1_q <= issue;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A single access slot: one pixel either parks or fetches, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && issue.rd))
    else $error("line buffer written and read by the same pixel");

  // Every read lands in stage one on the following edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.rd |=> s1_valid_q)
    else $error("line buffer read lost before stage one");

  // Stage one only fills from a read issued in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(issue.rd))
    else $error("stage one filled without a line buffer read");

  // Input back-pressure only while both pipeline stages are occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

endmodule

// ===== hdl/tbds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tbds_ram #(
  parameter int unsigned WIDTH = 45,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tbds_front.sv =====
// Position counters, even-column hold and line buffer access issue.
module tbds_front #(
  parameter int unsigned TILE_WIDTH   = 64,
  parameter int unsigned MAX_CHANNELS = 5,
  parameter int unsigned AW           = 5
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       accept_i,
  input  tbds_pkg::in_item_t                         item_i,
  output logic                                       we_o,
  output logic [AW-1:0]                              addr_o,
  output logic [MAX_CHANNELS*tbds_pkg::LANE_W-1:0]   wdata_o,
  output tbds_pkg::issue_t                           issue_o
);

  localparam int unsigned CW   = $clog2(TILE_WIDTH);
  localparam int unsigned HALF = TILE_WIDTH / 2;
  localparam int unsigned MW   = MAX_CHANNELS * tbds_pkg::LANE_W;
  localparam int unsigned FW   = tbds_pkg::LANES * tbds_pkg::LANE_W;

  logic [CW-1:0]           col_q, col_d, row_q, row_d;
  logic [CW-1:0]           col, row;
  logic [MW-1:0]           hold_q, hold_d;
  tbds_pkg::lanes_t        smp, hold_ext, pairs;
  logic                    quad_x, quad_y;

  always_comb begin
    col = item_i.first_of_tile ? '0 : col_q;
    row = item_i.first_of_tile ? '0 : row_q;

    smp[0] = {1'b0, item_i.chan_0};
    smp[1] = {1'b0, item_i.chan_1};
    smp[2] = {1'b0, item_i.chan_2};
    smp[3] = {1'b0, item_i.chan_3};
    smp[4] = {1'b0, item_i.chan_4};

    hold_ext = tbds_pkg::lanes_t'(FW'(hold_q));
    for (int c = 0; c < int'(tbds_pkg::LANES); c++) begin
      pairs[c] = hold_ext[c] + smp[c];
    end

    hold_d = hold_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept_i) begin
      if (!col[0]) begin
        hold_d = MW'(smp);
      end
      if (col == CW'(TILE_WIDTH - 1)) begin
        col_d = '0;
        row_d = (row == CW'(TILE_WIDTH - 1)) ? '0 : row + 1'b1;
      end else begin
        col_d = col + 1'b1;
        row_d = row;
      end
    end

    quad_x = (item_i.quadrant == tbds_pkg::QUAD_TOP_RIGHT) ||
             (item_i.quadrant == tbds_pkg::QUAD_BOTTOM_RIGHT);
    quad_y = (item_i.quadrant == tbds_pkg::QUAD_BOTTOM_RIGHT) ||
             (item_i.quadrant == tbds_pkg::QUAD_BOTTOM_LEFT);

    // Even rows park their pair sums; odd rows fetch them back.
    we_o    = accept_i && col[0] && !row[0];
    addr_o  = AW'(col >> 1);
    wdata_o = MW'(pairs);

    issue_o.rd    = accept_i && col[0] && row[0];
    issue_o.dst_x = tbds_pkg::COORD_W'(col >> 1) +
                    (quad_x ? tbds_pkg::COORD_W'(HALF) : '0);
    issue_o.dst_y = tbds_pkg::COORD_W'(row >> 1) +
                    (quad_y ? tbds_pkg::COORD_W'(HALF) : '0);
    issue_o.pairs = pairs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      hold_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      hold_q <= hold_d;
    end
  end

endmodule

// ===== dv/tile_box_downsample_2x_test.sv =====
// Self-checking testbench for the 2x2 box downsampler that merges four tiles.
module tile_box_downsample_2x_test;

  // The block is built with its default geometry; the checker models the same.
  localparam int unsigned TILE_W       = 64;
  localparam int unsigned MAX_CH       = 5;
  localparam int unsigned HALF_W       = TILE_W / 2;
  // Idle margin after the last owed result, so that the pipeline can finish.
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [tbds_pkg::CFG_W-1:0]   cfg_data_i;

  tbds_stream_if #(.payload_t(tbds_pkg::in_item_t))  in_if ();
  tbds_stream_if #(.payload_t(tbds_pkg::out_item_t)) out_if ();

  tile_box_downsample_2x #(
    .TILE_WIDTH  (TILE_W),
    .MAX_CHANNELS(MAX_CH)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Shadow of the block's state. It is advanced by the sending process at the
  // edge where each pixel request is accepted, so the stimulus side can look
  // at it without racing the block.
  int unsigned                pos_col;
  int unsigned                pos_row;
  tbds_pkg::lanes_t           held_pixel;
  tbds_pkg::lanes_t           even_row_sums [HALF_W];
  bit                         sums_valid [HALF_W];
  logic [tbds_pkg::CFG_W-1:0] channel_setting;

  // Averaged pixels still owed by the block, oldest first.
  tbds_pkg::out_item_t        expected_pixels [$];

  int unsigned      error_count;
  int unsigned      cycle_count;
  int unsigned      burst_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [tbds_pkg::SAMPLE_W-1:0] got,
                             logic [tbds_pkg::SAMPLE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  // Works out what one accepted pixel does to the block. An even column only
  // latches its samples; an odd column forms the horizontal pair sum, which
  // an even row parks in the line buffer and an odd row combines with the
  // parked sum above it to emit one averaged pixel.
  function automatic void predict_pixel(tbds_pkg::in_item_t px);
    logic [tbds_pkg::SAMPLE_W-1:0] smp [tbds_pkg::LANES];
    logic [tbds_pkg::SAMPLE_W-1:0] avg [tbds_pkg::LANES];
    tbds_pkg::lanes_t              pairs;
    logic [tbds_pkg::SUM_W-1:0]    block_sum;
    tbds_pkg::out_item_t           res;
    tbds_pkg::quad_e               quad;
    int unsigned                   slot;
    int unsigned                   used;
    smp[0] = px.chan_0;
    smp[1] = px.chan_1;
    smp[2] = px.chan_2;
    smp[3] = px.chan_3;
    smp[4] = px.chan_4;
    quad   = tbds_pkg::quad_e'(px.quadrant);
    if (px.first_of_tile) begin
      pos_col = 0;
      pos_row = 0;
    end
    slot = pos_col / 2;
    if (pos_col % 2 == 0) begin
      for (int c = 0; c < int'(tbds_pkg::LANES); c++) begin
        held_pixel[c] = tbds_pkg::LANE_W'(smp[c]);
      end
    end else begin
      for (int c = 0; c < int'(tbds_pkg::LANES); c++) begin
        pairs[c] = held_pixel[c] + tbds_pkg::LANE_W'(smp[c]);
      end
      if (pos_row % 2 == 0) begin
        even_row_sums[slot] = pairs;
        sums_valid[slot]    = 1'b1;
      end else begin
        // The channel count is sampled only now, when the result is formed;
        // counts above the channel limit saturate.
        used = (channel_setting > MAX_CH) ? MAX_CH : channel_setting;
        for (int c = 0; c < int'(tbds_pkg::LANES); c++) begin
          block_sum = tbds_pkg::SUM_W'(even_row_sums[slot][c]) +
                      tbds_pkg::SUM_W'(pairs[c]);
          avg[c]    = (c < used) ? block_sum[tbds_pkg::SUM_W-1:2] : '0;
        end
        // The quadrant of the emitting pixel alone picks the offset.
        res.dst_x = tbds_pkg::COORD_W'(slot +
                      ((quad == tbds_pkg::QUAD_TOP_RIGHT ||
                        quad == tbds_pkg::QUAD_BOTTOM_RIGHT) ? HALF_W : 0));
        res.dst_y = tbds_pkg::COORD_W'(pos_row / 2 +
                      ((quad == tbds_pkg::QUAD_BOTTOM_RIGHT ||
                        quad == tbds_pkg::QUAD_BOTTOM_LEFT) ? HALF_W : 0));
        res.avg_0 = avg[0];
        res.avg_1 = avg[1];
        res.avg_2 = avg[2];
        res.avg_3 = avg[3];
        res.avg_4 = avg[4];
        expected_pixels.push_back(res);
      end
    end
    // Row-major walk with wrap at the end of each row and of the tile.
    pos_col++;
    if (pos_col >= TILE_W) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= TILE_W) pos_row = 0;
    end
  endfunction

  // Sends one pixel request. The sender works in bursts; at the start of each
  // burst it may drop valid for a random gap. A pixel that would make an odd
  // row read a line buffer entry that no even row has written yet is turned
  // into a tile restart instead, since that read has no defined result.
  task automatic send_pixel(tbds_pkg::in_item_t px);
    int unsigned gap;
    if (pos_col % 2 == 1 && pos_row % 2 == 1 && !sums_valid[pos_col / 2]) begin
      px.first_of_tile = 1'b1;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= px;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_pixel(px);
  endtask

  function automatic tbds_pkg::in_item_t random_pixel(tbds_pkg::quad_e quad, bit first);
    tbds_pkg::in_item_t px;
    px.quadrant      = quad;
    px.first_of_tile = first;
    px.chan_0        = tbds_pkg::SAMPLE_W'($urandom_range(0, 255));
    px.chan_1        = tbds_pkg::SAMPLE_W'($urandom_range(0, 255));
    px.chan_2        = tbds_pkg::SAMPLE_W'($urandom_range(0, 255));
    px.chan_3        = tbds_pkg::SAMPLE_W'($urandom_range(0, 255));
    px.chan_4        = tbds_pkg::SAMPLE_W'($urandom_range(0, 255));
    return px;
  endfunction

  // Streams n random pixels. Most follow the given quadrant; flip_pct percent
  // take a random one, and restart_permille per mille restart the tile.
  task automatic send_stream(int unsigned n, tbds_pkg::quad_e quad, int unsigned flip_pct,
                             int unsigned restart_permille);
    tbds_pkg::quad_e pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = ($urandom_range(0, 99) < flip_pct) ?
             tbds_pkg::quad_e'($urandom_range(0, 3)) : quad;
      send_pixel(random_pixel(pick, $urandom_range(0, 999) < restart_permille));
    end
  endtask

  // Drops valid, then waits until every owed result has come out and the
  // pipeline has had time to finish any pixel that gives no result.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_channel_count(logic [tbds_pkg::CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    channel_setting = value;
    cfg_we_i   <= 1'b0;
  endtask

  // Saturated and empty blocks with the reset channel count: all-ones gives
  // 255, all-zeros 0, and three 255s with a 254 truncate to 254. Channel 4
  // must read zero because the reset count is four.
  task automatic test_extremes();
    tbds_pkg::in_item_t            px;
    logic [tbds_pkg::SAMPLE_W-1:0] val;
    for (int unsigned row = 0; row < 2; row++) begin
      for (int unsigned col = 0; col < TILE_W; col++) begin
        case ((col / 2) % 3)
          0: val = 8'hFF;
          1: val = 8'h00;
          default: val = (row == 1 && col % 2 == 1) ? 8'hFE : 8'hFF;
        endcase
        px.quadrant      = tbds_pkg::QUAD_TOP_LEFT;
        px.first_of_tile = (row == 0 && col == 0);
        px.chan_0        = val;
        px.chan_1        = val;
        px.chan_2        = val;
        px.chan_3        = val;
        px.chan_4        = val;
        send_pixel(px);
      end
    end
  endtask

  // Per quadrant, a restarted even row and the start of the odd row below
  // it; then more of that odd row with the quadrant changing from pixel to
  // pixel inside the tile.
  task automatic test_quadrants();
    for (int q = 0; q < 4; q++) begin
      send_pixel(random_pixel(tbds_pkg::quad_e'(q), 1'b1));
      send_stream(TILE_W - 1, tbds_pkg::quad_e'(q), 0, 0);
      send_stream(8, tbds_pkg::quad_e'(q), 0, 0);
    end
    send_stream(16, tbds_pkg::QUAD_TOP_LEFT, 50, 0);
  endtask

  // Every channel count, including zero and the values above the limit. One
  // even row is sent first; the count then changes every few pixels of the
  // odd row below, so each change lands in the middle of a tile.
  task automatic test_channel_counts();
    tbds_pkg::quad_e quad;
    quad = tbds_pkg::quad_e'($urandom_range(0, 3));
    send_pixel(random_pixel(quad, 1'b1));
    send_stream(TILE_W - 1, quad, 0, 0);
    for (int v = 0; v < 8; v++) begin
      wait_for_drain();
      write_channel_count(tbds_pkg::CFG_W'(v));
      send_stream(8, quad, 0, 0);
    end
  endtask

  // Mostly orderly rows with random samples, sprinkled with tile restarts and
  // quadrant changes, in phases separated by a full drain and a new count.
  // The rows continue past the first pair, so column wrap into later rows
  // and later row pairs are exercised too.
  task automatic test_random();
    for (int phase = 0; phase < 2; phase++) begin
      wait_for_drain();
      write_channel_count(tbds_pkg::CFG_W'($urandom_range(0, 7)));
      send_stream(100, tbds_pkg::quad_e'($urandom_range(0, 3)), 5, 5);
    end
  endtask

  // The receiver switches at random among four behaviors: always ready,
  // randomly ready, a fixed one-in-four stall, or long stall runs.
  initial begin : drain_results
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    int unsigned phase_cnt;
    mode_left    = 0;
    stall_left   = 0;
    phase_cnt    = 0;
    mode         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      phase_cnt++;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= (phase_cnt % 4 != 0);
        default: begin
          if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10);
          end
          out_if.ready <= (stall_left == 0);
          if (stall_left != 0) stall_left--;
        end
      endcase
    end
  end

  // Every accepted result is matched against the oldest owed pixel.
  always @(posedge clk_i) begin : check_results
    tbds_pkg::out_item_t got;
    tbds_pkg::out_item_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = out_if.data;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result at x=%0d y=%0d",
                                  got.dst_x, got.dst_y));
      end else begin
        want = expected_pixels.pop_front();
        check_field("dst_x", tbds_pkg::SAMPLE_W'(got.dst_x),
                    tbds_pkg::SAMPLE_W'(want.dst_x));
        check_field("dst_y", tbds_pkg::SAMPLE_W'(got.dst_y),
                    tbds_pkg::SAMPLE_W'(want.dst_y));
        check_field("avg_0", got.avg_0, want.avg_0);
        check_field("avg_1", got.avg_1, want.avg_1);
        check_field("avg_2", got.avg_2, want.avg_2);
        check_field("avg_3", got.avg_3, want.avg_3);
        check_field("avg_4", got.avg_4, want.avg_4);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.data      = '0;
    error_count     = 0;
    cycle_count     = 0;
    burst_left      = 0;
    pos_col         = 0;
    pos_row         = 0;
    held_pixel      = '0;
    channel_setting = tbds_pkg::CHANNEL_COUNT_RST;
    for (int i = 0; i < HALF_W; i++) sums_valid[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_quadrants();
    test_channel_counts();
    test_random();
    wait_for_drain();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tbds_pkg.sv
hdl/tbds_stream_if.sv
hdl/tbds_ram.sv
hdl/tbds_front.sv
hdl/tile_box_downsample_2x.sv
dv/tile_box_downsample_2x_test.sv
